[sv/dd_odo_pkg.sv]
// Shared types, constants and tables for the odometry / wall heading block.
`timescale 1ns / 1ps
package dd_odo_pkg;

    localparam int SCAN_SAMPLES_DEF = 1024;
    localparam int CORDIC_STEPS_DEF = 16;

    // datapath widths
    localparam int CNT_W  = 6;   // step counter, covers the modulo sweep
    localparam int XY_W   = 30;  // CORDIC x/y
    localparam int Z_W    = 20;  // CORDIC angle, Q.16
    localparam int A_W    = 42;  // multiplier A operand (split in two halves)
    localparam int B_W    = 21;  // multiplier B operand
    localparam int HALF_W = 21;  // A split point
    localparam int P_W    = 43;  // partial product
    localparam int ACC_W  = 64;
    localparam int WD_W   = 54;  // wheel distance, Q.24
    localparam int H_W    = 49;  // heading sum before wrap
    localparam int TRIG_W = 18;  // sin / cos, Q.16

    localparam int MOD_TOP = 33; // highest shift of 2pi in the wrap sweep

    localparam int PI_Q13      = 25736;
    localparam int TWO_PI_Q13  = 51472;
    localparam int HALF_PI_Q13 = 12868;
    localparam int CORDIC_INIT = 39797;
    localparam int ROOT2_Q14   = 23170;

    // config register indexes
    localparam logic [2:0] REG_MIN_RANGE    = 3'd0;
    localparam logic [2:0] REG_MAX_RANGE    = 3'd1;
    localparam logic [2:0] REG_WALL_DIST    = 3'd2;
    localparam logic [2:0] REG_RIGHT_INDEX  = 3'd3;
    localparam logic [2:0] REG_CENTER_INDEX = 3'd4;
    localparam logic [2:0] REG_M_PER_TICK   = 3'd5;
    localparam logic [2:0] REG_INV_TRACK    = 3'd6;

    // datapath commands
    localparam logic [3:0] CMD_NOP      = 4'd0;
    localparam logic [3:0] CMD_LATCH    = 4'd1;
    localparam logic [3:0] CMD_DELTA    = 4'd2;
    localparam logic [3:0] CMD_MUL_LO   = 4'd3;
    localparam logic [3:0] CMD_MUL_HI   = 4'd4;
    localparam logic [3:0] CMD_STORE    = 4'd5;
    localparam logic [3:0] CMD_MEANDIFF = 4'd6;
    localparam logic [3:0] CMD_ROT_INIT = 4'd7;
    localparam logic [3:0] CMD_CSTEP    = 4'd8;
    localparam logic [3:0] CMD_ROT_DONE = 4'd9;
    localparam logic [3:0] CMD_MOD_STEP = 4'd10;
    localparam logic [3:0] CMD_MOD_DONE = 4'd11;
    localparam logic [3:0] CMD_VEC_INIT = 4'd12;
    localparam logic [3:0] CMD_VEC_DONE = 4'd13;
    localparam logic [3:0] CMD_FINISH   = 4'd14;

    // multiply selects
    localparam logic [2:0] SEL_LD   = 3'd0;
    localparam logic [2:0] SEL_RD   = 3'd1;
    localparam logic [2:0] SEL_DX   = 3'd2;
    localparam logic [2:0] SEL_DY   = 3'd3;
    localparam logic [2:0] SEL_TURN = 3'd4;
    // CORDIC mode selects
    localparam logic [2:0] SEL_ROT  = 3'd0;
    localparam logic [2:0] SEL_VEC  = 3'd1;

    typedef struct packed {
        logic [3:0]       op;
        logic [2:0]       sel;
        logic [CNT_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    // atan(2^-i) in Q.16
    function automatic logic [Z_W-1:0] atan_q16(input logic [4:0] i);
        logic [Z_W-1:0] v;
        case (i)
            5'd0:    v = Z_W'(51472);
            5'd1:    v = Z_W'(30385);
            5'd2:    v = Z_W'(16055);
            5'd3:    v = Z_W'(8150);
            5'd4:    v = Z_W'(4091);
            5'd5:    v = Z_W'(2047);
            5'd6:    v = Z_W'(1024);
            5'd7:    v = Z_W'(512);
            5'd8:    v = Z_W'(256);
            5'd9:    v = Z_W'(128);
            5'd10:   v = Z_W'(64);
            5'd11:   v = Z_W'(32);
            5'd12:   v = Z_W'(16);
            5'd13:   v = Z_W'(8);
            5'd14:   v = Z_W'(4);
            5'd15:   v = Z_W'(2);
            5'd16:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[sv/dd_odo_ifs.sv]
// Channel interfaces: input items, result items, config writes.
`timescale 1ns / 1ps
interface dd_odo_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [9:0]         range_index;
    logic [15:0]        range_value;
    logic signed [31:0] ticks_left;
    logic signed [31:0] ticks_right;
    modport source(output valid, op, range_index, range_value, ticks_left, ticks_right,
                   input ready);
    modport sink(input valid, op, range_index, range_value, ticks_left, ticks_right,
                 output ready);
endinterface

interface dd_odo_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] wall_heading;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    modport source(output valid, wall_heading, pose_x, pose_y, pose_heading, input ready);
    modport sink(input valid, wall_heading, pose_x, pose_y, pose_heading, output ready);
endinterface

interface dd_odo_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [19:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[sv/diff_drive_odometry_wall_heading.sv]
// Top level: differential drive odometry with wall heading target.
//
//  channel | dir | words
//  i_in    | in  | op 0 scan sample (index, range), op 1 encoder counts
//  o_out   | out | wall_heading, pose_x, pose_y, pose_heading, one per op 1 word
//  i_cfg   | in  | register index 0..6 and data, always ready
//
// A scan sample word is latched while the sequencer stays idle. An encoder
// word runs from accept to ready again through five split multiplies (low
// half, high half, store) on the shared multiplier, a rotation and a vectoring
// CORDIC, a sweep over shifts MOD_TOP down to 0 that wraps the heading,
// and eight setup/hand-off steps.
// Reset is synchronous; it restores register defaults and clears the pose.
// A finished word sits in the output register; the next input word is taken
// while it waits, and the sequencer only stalls when a second result is ready.
`timescale 1ns / 1ps
module diff_drive_odometry_wall_heading import dd_odo_pkg::*; #(
    parameter int SCAN_SAMPLES = SCAN_SAMPLES_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dd_odo_in_if.sink     i_in,
    dd_odo_out_if.source  o_out,
    dd_odo_cfg_if.sink    i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // config writes are always accepted
    assign i_cfg.ready = 1'b1;

    dd_odo_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    dd_odo_dp #(
        .SCAN_SAMPLES(SCAN_SAMPLES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_range_index  (i_in.range_index),
        .i_range_value  (i_in.range_value),
        .i_ticks_left   (i_in.ticks_left),
        .i_ticks_right  (i_in.ticks_right),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_wall_heading (o_out.wall_heading),
        .o_pose_x       (o_out.pose_x),
        .o_pose_y       (o_out.pose_y),
        .o_pose_heading (o_out.pose_heading)
    );

endmodule

[sv/dd_odo_ctrl.sv]
// Sequencer for the odometry datapath.
`timescale 1ns / 1ps
module dd_odo_ctrl import dd_odo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_op,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MLO      = 4'd1;
    localparam logic [3:0] S_MHI      = 4'd2;
    localparam logic [3:0] S_STORE    = 4'd3;
    localparam logic [3:0] S_MEANDIFF = 4'd4;
    localparam logic [3:0] S_ROT_INIT = 4'd5;
    localparam logic [3:0] S_CSTEP    = 4'd6;
    localparam logic [3:0] S_ROT_DONE = 4'd7;
    localparam logic [3:0] S_MOD_STEP = 4'd8;
    localparam logic [3:0] S_MOD_DONE = 4'd9;
    localparam logic [3:0] S_VEC_INIT = 4'd10;
    localparam logic [3:0] S_VEC_DONE = 4'd11;
    localparam logic [3:0] S_FINISH   = 4'd12;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

    logic [3:0]       r_state, n_state;
    logic [2:0]       r_sel, n_sel;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_vec, n_vec;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_cnt      = r_cnt;
        n_vec      = r_vec;
        o_cmd.op   = CMD_NOP;
        o_cmd.sel  = r_sel;
        o_cmd.step = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op) begin
                        o_cmd.op = CMD_DELTA;
                        n_sel    = SEL_LD;
                        n_state  = S_MLO;
                    end else begin
                        o_cmd.op = CMD_LATCH;
                    end
                end
            end
            S_MLO: begin
                o_cmd.op = CMD_MUL_LO;
                n_state  = S_MHI;
            end
            S_MHI: begin
                o_cmd.op = CMD_MUL_HI;
                n_state  = S_STORE;
            end
            S_STORE: begin
                o_cmd.op = CMD_STORE;
                unique case (r_sel)
                    SEL_LD: begin
                        n_sel   = SEL_RD;
                        n_state = S_MLO;
                    end
                    SEL_RD:   n_state = S_MEANDIFF;
                    SEL_DX: begin
                        n_sel   = SEL_DY;
                        n_state = S_MLO;
                    end
                    SEL_DY: begin
                        n_sel   = SEL_TURN;
                        n_state = S_MLO;
                    end
                    SEL_TURN: begin
                        n_cnt   = CNT_W'(MOD_TOP);
                        n_state = S_MOD_STEP;
                    end
                    default:  n_state = S_IDLE;
                endcase
            end
            S_MEANDIFF: begin
                o_cmd.op = CMD_MEANDIFF;
                n_state  = S_ROT_INIT;
            end
            S_ROT_INIT: begin
                o_cmd.op = CMD_ROT_INIT;
                n_cnt    = '0;
                n_vec    = 1'b0;
                n_state  = S_CSTEP;
            end
            S_CSTEP: begin
                o_cmd.op  = CMD_CSTEP;
                o_cmd.sel = r_vec ? SEL_VEC : SEL_ROT;
                if (r_cnt == LAST_STEP) begin
                    n_state = r_vec ? S_VEC_DONE : S_ROT_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ROT_DONE: begin
                o_cmd.op = CMD_ROT_DONE;
                n_sel    = SEL_DX;
                n_state  = S_MLO;
            end
            S_MOD_STEP: begin
                o_cmd.op = CMD_MOD_STEP;
                if (r_cnt == '0) begin
                    n_state = S_MOD_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_MOD_DONE: begin
                o_cmd.op = CMD_MOD_DONE;
                n_state  = S_VEC_INIT;
            end
            S_VEC_INIT: begin
                o_cmd.op = CMD_VEC_INIT;
                n_cnt    = '0;
                n_vec    = 1'b1;
                n_state  = S_CSTEP;
            end
            S_VEC_DONE: begin
                o_cmd.op = CMD_VEC_DONE;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = CMD_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_LD;
            r_cnt   <= '0;
            r_vec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_cnt   <= n_cnt;
            r_vec   <= n_vec;
        end
    end

    a_enc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_in_op) |=> (r_state != S_IDLE))
        else $error("encoder word did not start the sequence");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == CMD_FINISH) |-> !i_stat.out_busy)
        else $error("result overwritten while pending");

    a_cordic_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CSTEP) |-> (r_cnt <= LAST_STEP))
        else $error("CORDIC step out of range");

    a_mod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD_STEP) |-> (r_cnt <= CNT_W'(MOD_TOP)))
        else $error("wrap sweep step out of range");

endmodule

[sv/dd_odo_dp.sv]
// Datapath: config, pose state, shared multiplier, CORDIC and heading wrap.
`timescale 1ns / 1ps
module dd_odo_dp import dd_odo_pkg::*; #(
    parameter int SCAN_SAMPLES = SCAN_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data,
    input  logic [9:0]         i_range_index,
    input  logic [15:0]        i_range_value,
    input  logic signed [31:0] i_ticks_left,
    input  logic signed [31:0] i_ticks_right,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_wall_heading,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic signed [15:0] o_pose_heading
);

    localparam logic [16:0] SCAN_LIM = 17'(SCAN_SAMPLES);

    // config
    logic [15:0] r_min_range, r_max_range, r_wall_dist, r_inv_track;
    logic [9:0]  r_right_index, r_center_index;
    logic [19:0] r_m_per_tick;

    // state
    logic [31:0]        r_last_l, r_last_r;
    logic [31:0]        r_pos_x, r_pos_y;
    logic signed [15:0] r_head;
    logic [15:0]        r_right, r_center;

    // work registers
    logic signed [31:0]     r_dl, r_dr;
    logic signed [WD_W-1:0] r_ld, r_rd;
    logic signed [A_W-1:0]  r_mean, r_diff;
    logic signed [TRIG_W-1:0] r_cos, r_sin;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [XY_W-1:0] r_cx, r_cy;
    logic signed [Z_W-1:0]  r_cz;
    logic                   r_flip, r_zero, r_hneg;
    logic [H_W-1:0]         r_m;
    logic signed [15:0]     r_wall;

    logic               r_out_valid;
    logic signed [15:0] r_o_wall, r_o_head;
    logic [31:0]        r_o_x, r_o_y;

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_wall_heading  = r_o_wall;
    assign o_pose_x        = r_o_x;
    assign o_pose_y        = r_o_y;
    assign o_pose_heading  = r_o_head;

    // shared multiplier, A split into a low and a high half
    logic signed [A_W-1:0] w_a;
    logic signed [B_W-1:0] w_b;
    logic signed [HALF_W:0] w_mop;
    logic signed [P_W-1:0] w_prod;

    always_comb begin
        case (i_cmd.sel)
            SEL_LD:   begin w_a = A_W'(r_dl);   w_b = $signed({1'b0, r_m_per_tick}); end
            SEL_RD:   begin w_a = A_W'(r_dr);   w_b = $signed({1'b0, r_m_per_tick}); end
            SEL_DX:   begin w_a = r_mean;       w_b = B_W'(r_cos); end
            SEL_DY:   begin w_a = r_mean;       w_b = B_W'(r_sin); end
            default:  begin w_a = r_diff;       w_b = $signed({5'd0, r_inv_track}); end
        endcase
        if (i_cmd.op == CMD_MUL_HI) begin
            w_mop = $signed({w_a[A_W-1], w_a[A_W-1:HALF_W]});
        end else begin
            w_mop = $signed({1'b0, w_a[HALF_W-1:0]});
        end
        w_prod = w_mop * w_b;
    end

    // pose step terms
    logic signed [ACC_W-1:0] w_sh16, w_sh11;
    logic signed [H_W-1:0]   w_hsum;
    assign w_sh16 = r_acc >>> 16;
    assign w_sh11 = r_acc >>> 11;
    assign w_hsum = H_W'(r_head) + w_sh11[H_W-1:0];

    logic signed [WD_W:0] w_lsum, w_ldif;
    assign w_lsum = (WD_W+1)'(r_ld) + (WD_W+1)'(r_rd);
    assign w_ldif = (WD_W+1)'(r_rd) - (WD_W+1)'(r_ld);

    // sin/cos fold
    logic signed [16:0] w_ang;
    logic               w_flip;
    always_comb begin
        w_ang  = 17'(r_head);
        w_flip = 1'b0;
        if (r_head > 16'sd12868) begin
            w_ang  = 17'(r_head) - 17'sd25736;
            w_flip = 1'b1;
        end else if (r_head < -16'sd12868) begin
            w_ang  = 17'(r_head) + 17'sd25736;
            w_flip = 1'b1;
        end
    end

    // CORDIC step
    logic [4:0]             w_i;
    logic signed [XY_W-1:0] w_sx, w_sy;
    logic signed [Z_W-1:0]  w_t;
    logic                   w_pos;
    assign w_i   = i_cmd.step[4:0];
    assign w_sx  = r_cx >>> w_i;
    assign w_sy  = r_cy >>> w_i;
    assign w_t   = $signed(atan_q16(w_i));
    assign w_pos = (i_cmd.sel == SEL_VEC) ? !r_cy[XY_W-1] : !r_cz[Z_W-1];

    // wall operands
    logic [30:0]        w_wd2;
    logic [15:0]        w_cr, w_cc;
    logic signed [18:0] w_us;
    assign w_wd2 = 31'(r_wall_dist) * 31'(ROOT2_Q14);
    always_comb begin
        if (r_right > r_max_range) w_cr = r_max_range;
        else if (r_right < r_min_range) w_cr = r_min_range;
        else w_cr = r_right;
        if (r_center > r_max_range) w_cc = r_max_range;
        else if (r_center < r_min_range) w_cc = r_min_range;
        else w_cc = r_center;
    end
    assign w_us = $signed({2'b00, w_wd2[30:14]}) - $signed({3'b000, w_cr});

    // atan2 result
    logic signed [Z_W-1:0] w_rz;
    logic signed [15:0]    w_wall;
    assign w_rz = (r_cz + Z_W'(4)) >>> 3;
    always_comb begin
        if (w_rz > Z_W'(PI_Q13)) w_wall = 16'(PI_Q13);
        else if (w_rz < -Z_W'(PI_Q13)) w_wall = -16'(PI_Q13);
        else w_wall = w_rz[15:0];
    end

    // wrap sweep and final heading
    logic [H_W-1:0]     w_sub;
    logic [16:0]        w_r;
    logic signed [17:0] w_hr;
    assign w_sub = H_W'(TWO_PI_Q13) << i_cmd.step;
    always_comb begin
        if (r_hneg && r_m != '0) w_r = 17'(TWO_PI_Q13) - r_m[16:0];
        else w_r = r_m[16:0];
        if (w_r > 17'(PI_Q13)) w_hr = $signed({1'b0, w_r}) - 18'sd51472;
        else w_hr = $signed({1'b0, w_r});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range    <= 16'd2048;
            r_max_range    <= 16'd16384;
            r_wall_dist    <= 16'd2253;
            r_right_index  <= 10'd12;
            r_center_index <= 10'd17;
            r_m_per_tick   <= 20'd41178;
            r_inv_track    <= 16'd13653;
            r_last_l       <= '0;
            r_last_r       <= '0;
            r_pos_x        <= '0;
            r_pos_y        <= '0;
            r_head         <= '0;
            r_right        <= '0;
            r_center       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MIN_RANGE:    r_min_range    <= i_cfg_data[15:0];
                    REG_MAX_RANGE:    r_max_range    <= i_cfg_data[15:0];
                    REG_WALL_DIST:    r_wall_dist    <= i_cfg_data[15:0];
                    REG_RIGHT_INDEX:  r_right_index  <= i_cfg_data[9:0];
                    REG_CENTER_INDEX: r_center_index <= i_cfg_data[9:0];
                    REG_M_PER_TICK:   r_m_per_tick   <= i_cfg_data;
                    REG_INV_TRACK:    r_inv_track    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // a new word may load in the cycle the old one is taken
            if (i_cmd.op == CMD_FINISH) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                CMD_LATCH: begin
                    if ({7'd0, i_range_index} < SCAN_LIM) begin
                        if (i_range_index == r_right_index) r_right <= i_range_value;
                        if (i_range_index == r_center_index) r_center <= i_range_value;
                    end
                end
                CMD_DELTA: begin
                    r_last_l <= i_ticks_left;
                    r_last_r <= i_ticks_right;
                end
                CMD_STORE: begin
                    case (i_cmd.sel)
                        SEL_DX: r_pos_x <= r_pos_x + w_sh16[31:0];
                        SEL_DY: r_pos_y <= r_pos_y + w_sh16[31:0];
                        default: ;
                    endcase
                end
                CMD_MOD_DONE: r_head <= w_hr[15:0];
                default: ;
            endcase
        end
    end

    // payload and work registers, no reset
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_DELTA: begin
                r_dl <= $signed(i_ticks_left - r_last_l);
                r_dr <= $signed(i_ticks_right - r_last_r);
            end
            CMD_MUL_LO: r_acc <= ACC_W'(w_prod);
            CMD_MUL_HI: r_acc <= r_acc + (ACC_W'(w_prod) <<< HALF_W);
            CMD_STORE: begin
                case (i_cmd.sel)
                    SEL_LD: r_ld <= r_acc[WD_W-1:0];
                    SEL_RD: r_rd <= r_acc[WD_W-1:0];
                    SEL_TURN: begin
                        r_hneg <= w_hsum[H_W-1];
                        r_m    <= w_hsum[H_W-1] ? H_W'(-w_hsum) : H_W'(w_hsum);
                    end
                    default: ;
                endcase
            end
            CMD_MEANDIFF: begin
                r_mean <= w_lsum[WD_W:13];
                r_diff <= w_ldif[WD_W-1:12];
            end
            CMD_ROT_INIT: begin
                r_cx   <= XY_W'(CORDIC_INIT);
                r_cy   <= '0;
                r_cz   <= Z_W'(w_ang) <<< 3;
                r_flip <= w_flip;
            end
            CMD_CSTEP: begin
                if (i_cmd.sel == SEL_VEC) begin
                    if (w_pos) begin
                        r_cx <= r_cx + w_sy;
                        r_cy <= r_cy - w_sx;
                        r_cz <= r_cz + w_t;
                    end else begin
                        r_cx <= r_cx - w_sy;
                        r_cy <= r_cy + w_sx;
                        r_cz <= r_cz - w_t;
                    end
                end else begin
                    if (w_pos) begin
                        r_cx <= r_cx - w_sy;
                        r_cy <= r_cy + w_sx;
                        r_cz <= r_cz - w_t;
                    end else begin
                        r_cx <= r_cx + w_sy;
                        r_cy <= r_cy - w_sx;
                        r_cz <= r_cz + w_t;
                    end
                end
            end
            CMD_ROT_DONE: begin
                r_cos <= r_flip ? -r_cx[TRIG_W-1:0] : r_cx[TRIG_W-1:0];
                r_sin <= r_flip ? -r_cy[TRIG_W-1:0] : r_cy[TRIG_W-1:0];
            end
            CMD_MOD_STEP: begin
                if (r_m >= w_sub) r_m <= r_m - w_sub;
            end
            CMD_VEC_INIT: begin
                r_cx   <= XY_W'($signed({1'b0, w_cc})) <<< 8;
                r_cy   <= XY_W'(w_us) <<< 8;
                r_cz   <= '0;
                r_zero <= (w_us == '0) && (w_cc == '0);
            end
            CMD_VEC_DONE: r_wall <= r_zero ? 16'sd0 : w_wall;
            CMD_FINISH: begin
                r_o_wall <= r_wall;
                r_o_x    <= r_pos_x;
                r_o_y    <= r_pos_y;
                r_o_head <= r_head;
            end
            default: ;
        endcase
    end

endmodule

[sim/diff_drive_odometry_wall_heading_tb.sv]
// Testbench for the odometry / wall heading block: directed and random words, scoreboard check.
`timescale 1ns / 1ps
module diff_drive_odometry_wall_heading_tb;
    import dd_odo_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int N_RANDOM       = 1950;

    typedef struct packed {
        logic        op;
        logic [9:0]  range_index;
        logic [15:0] range_value;
        logic [31:0] ticks_left;
        logic [31:0] ticks_right;
    } t_in_word;

    typedef struct packed {
        logic [15:0] wall_heading;
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [15:0] pose_heading;
    } t_pose_word;

    logic i_clk;
    logic i_rst_n;

    dd_odo_in_if  in_ch();
    dd_odo_out_if out_ch();
    dd_odo_cfg_if cfg_ch();

    diff_drive_odometry_wall_heading DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // ---------------------------------------------------------------
    // Predictor state: configuration and pose copy
    // ---------------------------------------------------------------
    longint cf_min, cf_max, cf_wall, cf_right_idx, cf_center_idx, cf_mpt, cf_inv_tw;
    logic [31:0] prev_left, prev_right, acc_x, acc_y;
    longint      cur_heading;
    logic [15:0] right_range, center_range;

    t_in_word   word_queue[$];
    t_pose_word pose_queue[$];
    int  fail_count;
    bit  stim_done;
    bit  no_idle;       // last part of the run: no gaps either side
    bit  hold_sink;     // long receiver hold-off request
    int  hold_count;

    // Floor division by 2^s for signed values (>>> on longint floors).
    function automatic longint fl_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(input int i);
        return longint'(atan_q16(5'(i)));
    endfunction

    // Rotation CORDIC: sin and cos of a Q3.13 angle, Q.16 results.
    task automatic heading_sin_cos(input longint ang, output longint s, output longint c);
        longint x, y, z, nx;
        bit flip;
        x = CORDIC_INIT; y = 0; flip = 0;
        if (ang > HALF_PI_Q13) begin
            ang -= PI_Q13; flip = 1;
        end else if (ang < -HALF_PI_Q13) begin
            ang += PI_Q13; flip = 1;
        end
        z = ang * 8;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            if (z >= 0) begin
                nx = x - fl_shift(y, i); y = y + fl_shift(x, i); z -= atan_entry(i);
            end else begin
                nx = x + fl_shift(y, i); y = y - fl_shift(x, i); z += atan_entry(i);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Vectoring CORDIC: atan2 in Q3.13, rounded half up from Q.16.
    function automatic longint wall_angle(input longint yin, input longint xin);
        longint x, y, z, nx, r;
        if (xin == 0 && yin == 0) return 0;
        x = xin * 256; y = yin * 256; z = 0;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            if (y >= 0) begin
                nx = x + fl_shift(y, i); y = y - fl_shift(x, i); z += atan_entry(i);
            end else begin
                nx = x - fl_shift(y, i); y = y + fl_shift(x, i); z -= atan_entry(i);
            end
            x = nx;
        end
        r = fl_shift(z + 4, 3);
        if (r > PI_Q13) r = PI_Q13;
        if (r < -PI_Q13) r = -PI_Q13;
        return r;
    endfunction

    function automatic longint clamp_sample(input longint v);
        if (v > cf_max) return cf_max;
        if (v < cf_min) return cf_min;
        return v;
    endfunction

    task automatic predictor_reset();
        cf_min = 2048; cf_max = 16384; cf_wall = 2253;
        cf_right_idx = 12; cf_center_idx = 17;
        cf_mpt = 41178; cf_inv_tw = 13653;
        prev_left = 0; prev_right = 0; acc_x = 0; acc_y = 0;
        cur_heading = 0; right_range = 0; center_range = 0;
    endtask

    task automatic predictor_config(input logic [2:0] idx, input logic [19:0] val);
        case (idx)
            REG_MIN_RANGE:    cf_min        = val[15:0];
            REG_MAX_RANGE:    cf_max        = val[15:0];
            REG_WALL_DIST:    cf_wall       = val[15:0];
            REG_RIGHT_INDEX:  cf_right_idx  = val[9:0];
            REG_CENTER_INDEX: cf_center_idx = val[9:0];
            REG_M_PER_TICK:   cf_mpt        = val;
            REG_INV_TRACK:    cf_inv_tw     = val[15:0];
            default: ;
        endcase
    endtask

    // Advance the predicted pose for one accepted word; queue a result for encoder words.
    task automatic odometry_update(input t_in_word w);
        longint dl, dr, ld, rd, mean12, diff12, s, c, dx, dy, turn, h, us, uf;
        t_pose_word p;
        if (w.op == 1'b0) begin
            if (longint'(w.range_index) < SCAN_SAMPLES_DEF) begin
                if (w.range_index == cf_right_idx)  right_range  = w.range_value;
                if (w.range_index == cf_center_idx) center_range = w.range_value;
            end
            return;
        end
        dl = longint'($signed(w.ticks_left - prev_left));
        dr = longint'($signed(w.ticks_right - prev_right));
        prev_left = w.ticks_left; prev_right = w.ticks_right;
        ld = dl * cf_mpt; rd = dr * cf_mpt;
        mean12 = fl_shift(ld + rd, 13);
        diff12 = fl_shift(rd - ld, 12);
        heading_sin_cos(cur_heading, s, c);
        dx = fl_shift(mean12 * c, 16);
        dy = fl_shift(mean12 * s, 16);
        acc_x += dx[31:0]; acc_y += dy[31:0];
        turn = fl_shift(diff12 * cf_inv_tw, 11);
        h = (cur_heading + turn) % TWO_PI_Q13;
        if (h < 0) h += TWO_PI_Q13;
        if (h > PI_Q13) h -= TWO_PI_Q13;
        cur_heading = h;
        uf = clamp_sample(center_range);
        us = fl_shift(cf_wall * ROOT2_Q14, 14) - clamp_sample(right_range);
        p.wall_heading = 16'(wall_angle(us, uf));
        p.pose_x = acc_x; p.pose_y = acc_y;
        p.pose_heading = 16'(cur_heading);
        pose_queue.push_back(p);
    endtask

    // ---------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Driver: pops words from word_queue, inserting random gaps of idle cycles
    // ---------------------------------------------------------------
    int src_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                odometry_update(word_queue.pop_front());
                if (!no_idle && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 17);
            end
            if (src_gap > 0) begin
                src_gap--;
                in_ch.valid <= 1'b0;
            end else if (word_queue.size() > 0) begin
                in_ch.valid       <= 1'b1;
                in_ch.op          <= word_queue[0].op;
                in_ch.range_index <= word_queue[0].range_index;
                in_ch.range_value <= word_queue[0].range_value;
                in_ch.ticks_left  <= word_queue[0].ticks_left;
                in_ch.ticks_right <= word_queue[0].ticks_right;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each result word against the oldest prediction
    // ---------------------------------------------------------------
    int sink_gap;
    always @(posedge i_clk) begin
        t_pose_word exp_w;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_gap = 0;
            hold_count = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pose_queue.size() == 0) begin
                    $error("unexpected result word");
                    fail_count++;
                end else begin
                    exp_w = pose_queue.pop_front();
                    if (out_ch.wall_heading !== exp_w.wall_heading) begin
                        $error("wall_heading exp %0d got %0d",
                               $signed(exp_w.wall_heading), out_ch.wall_heading);
                        fail_count++;
                    end
                    if (out_ch.pose_x !== exp_w.pose_x) begin
                        $error("pose_x exp %0d got %0d", $signed(exp_w.pose_x), out_ch.pose_x);
                        fail_count++;
                    end
                    if (out_ch.pose_y !== exp_w.pose_y) begin
                        $error("pose_y exp %0d got %0d", $signed(exp_w.pose_y), out_ch.pose_y);
                        fail_count++;
                    end
                    if (out_ch.pose_heading !== exp_w.pose_heading) begin
                        $error("pose_heading exp %0d got %0d",
                               $signed(exp_w.pose_heading), out_ch.pose_heading);
                        fail_count++;
                    end
                end
                if (!no_idle && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 17);
            end
            // Long hold-off so the block backs up and stalls its input.
            if (hold_sink && hold_count < 2000) begin
                hold_count++;
                out_ch.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: cycles without any accepted word
    // ---------------------------------------------------------------
    int quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (hold_sink && hold_count < 2000) || stim_done)
            quiet_cycles <= 0;
        else if (word_queue.size() > 0 || pose_queue.size() > 0) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    logic [31:0] enc_left, enc_right;   // running absolute counts

    function automatic t_in_word range_word(input logic [9:0] idx, input logic [15:0] v);
        t_in_word w;
        w = '0; w.op = 1'b0; w.range_index = idx; w.range_value = v;
        w.ticks_left = $urandom; w.ticks_right = $urandom;
        return w;
    endfunction

    function automatic t_in_word enc_word(input logic [31:0] l, input logic [31:0] r);
        t_in_word w;
        w.op = 1'b1; w.ticks_left = l; w.ticks_right = r;
        w.range_index = 10'($urandom); w.range_value = 16'($urandom);
        return w;
    endfunction

    task automatic push_encoder_step(input int span);
        enc_left  += 32'($signed($urandom_range(0, 2 * span)) - span);
        enc_right += 32'($signed($urandom_range(0, 2 * span)) - span);
        word_queue.push_back(enc_word(enc_left, enc_right));
    endtask

    // Wait until everything queued has gone through and the block is idle.
    task automatic drain();
        wait (word_queue.size() == 0 && pose_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        predictor_config(idx, val);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random phase: mostly scan samples at the watched indexes and moderate encoder steps.
    task automatic random_phase(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 20)
                word_queue.push_back(range_word(10'(cf_right_idx), 16'($urandom)));
            else if (k < 40)
                word_queue.push_back(range_word(10'(cf_center_idx), 16'($urandom)));
            else if (k < 48)
                word_queue.push_back(range_word(10'($urandom), 16'($urandom)));
            else if (k < 90)
                push_encoder_step(k < 80 ? 400 : 40000);
            else if (k < 96) begin
                enc_left = $urandom; enc_right = $urandom;
                word_queue.push_back(enc_word(enc_left, enc_right));
            end else
                push_encoder_step(1 << 30);
        end
    endtask

    initial begin
        fail_count = 0; stim_done = 0; no_idle = 0; hold_sink = 0;
        in_ch.valid = 0; in_ch.op = 0; in_ch.range_index = 0; in_ch.range_value = 0;
        in_ch.ticks_left = 0; in_ch.ticks_right = 0;
        out_ch.ready = 0;
        cfg_ch.valid = 0; cfg_ch.index = REG_MIN_RANGE; cfg_ch.data = 0;
        enc_left = 0; enc_right = 0;
        predictor_reset();
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, clamp both ways, index beyond watched, zero operands.
        word_queue.push_back(enc_word(0, 0));
        word_queue.push_back(range_word(10'(cf_right_idx), 16'hFFFF));
        word_queue.push_back(range_word(10'(cf_center_idx), 16'h0000));
        word_queue.push_back(enc_word(32'h7FFF_FFFF, 32'h8000_0000));
        word_queue.push_back(range_word(10'h3FF, 16'h1234));
        word_queue.push_back(range_word(10'(cf_right_idx), 16'd100));
        word_queue.push_back(range_word(10'(cf_center_idx), 16'd30000));
        word_queue.push_back(enc_word(32'h8000_0000, 32'h7FFF_FFFF));
        word_queue.push_back(enc_word(32'hFFFF_FFFF, 32'h0000_0000));
        word_queue.push_back(enc_word(32'h0000_1000, 32'h0000_3000));
        word_queue.push_back(enc_word(32'h0000_1000, 32'h0000_1000));
        enc_left = 32'h1000; enc_right = 32'h1000;
        drain();

        // Both atan2 operands zero and the heading frozen.
        write_reg(REG_MIN_RANGE, 0);
        write_reg(REG_MAX_RANGE, 20'hFFFF);
        write_reg(REG_WALL_DIST, 0);
        write_reg(REG_INV_TRACK, 0);
        write_reg(REG_RIGHT_INDEX, 10'h3FF);
        write_reg(REG_CENTER_INDEX, 10'h3FF);
        word_queue.push_back(range_word(10'h3FF, 16'd0));
        push_encoder_step(5000);
        push_encoder_step(5000);
        drain();

        // Extreme settings.
        write_reg(REG_WALL_DIST, 20'hFFFF);
        write_reg(REG_M_PER_TICK, 20'hFFFFF);
        write_reg(REG_INV_TRACK, 20'hFFFF);
        write_reg(REG_RIGHT_INDEX, 0);
        write_reg(REG_CENTER_INDEX, 0);
        random_phase(300);
        drain();

        write_reg(REG_M_PER_TICK, 0);
        write_reg(REG_INV_TRACK, 1);
        write_reg(REG_MIN_RANGE, 20'hFFFF);
        write_reg(REG_MAX_RANGE, 0);
        random_phase(150);
        drain();

        // Pressure: receiver holds off while words keep coming.
        write_reg(REG_MIN_RANGE, 2048);
        write_reg(REG_MAX_RANGE, 16384);
        write_reg(REG_WALL_DIST, 2253);
        write_reg(REG_RIGHT_INDEX, 12);
        write_reg(REG_CENTER_INDEX, 17);
        write_reg(REG_M_PER_TICK, 41178);
        write_reg(REG_INV_TRACK, 13653);
        hold_sink = 1;
        for (int i = 0; i < 20; i++) push_encoder_step(300);
        random_phase(700);
        wait (hold_count >= 2000);
        drain();

        write_reg(REG_RIGHT_INDEX, 20'($urandom));
        write_reg(REG_CENTER_INDEX, 20'($urandom));
        write_reg(REG_WALL_DIST, 20'($urandom));
        write_reg(REG_M_PER_TICK, 20'($urandom));
        write_reg(REG_INV_TRACK, 20'($urandom_range(1, 65535)));
        random_phase(500);
        drain();

        // Final stretch with no idling.
        no_idle = 1;
        random_phase(300);
        drain();
        stim_done = 1;

        if (fail_count == 0 && pose_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
